>>> rtl/core/qpid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qpid_pkg: shared constants and types of the quad PID velocity controller
// Widths, gain scaling, register indexes and the pipeline control bundle.
// ---------------------------------------------------------------------------
package qpid_pkg;

    localparam int CHANNELS       = 4;
    localparam int IO_LANES       = 4;
    localparam int FRAC_BITS      = 24;
    localparam int INTEGRAL_WIDTH = 40;

    localparam int GAIN_W   = 32;
    localparam int VALUE_W  = 16;
    localparam int ERR_W    = VALUE_W + 1;
    localparam int DERR_W   = ERR_W + 1;
    localparam int TORQUE_W = 15;
    localparam int CFG_IDX_W = 2;

    // The integral is multiplied in two halves so no product exceeds 33 x 20 bits.
    localparam int INT_LO_W  = INTEGRAL_WIDTH / 2;
    localparam int INT_HI_W  = INTEGRAL_WIDTH - INT_LO_W;
    localparam int KI_PROD_W = GAIN_W + 1 + INTEGRAL_WIDTH;
    localparam int U_W       = 64;
    localparam int KI_EXT_W  = (KI_PROD_W > U_W) ? KI_PROD_W : U_W;
    localparam int KP_PROD_W = GAIN_W + 1 + ERR_W;
    localparam int KD_PROD_W = GAIN_W + 1 + DERR_W;
    localparam int PD_W      = KD_PROD_W + 1;

    localparam logic signed [U_W-1:0]       KI_TERM_LIMIT = 64'sh2000_0000_0000_0000;
    localparam logic        [TORQUE_W-2:0]  TORQUE_LIMIT  = 14'd16383;

    localparam logic [GAIN_W-1:0] KP_RESET = 32'd4194304;
    localparam logic [GAIN_W-1:0] KI_RESET = 32'd84;
    localparam logic [GAIN_W-1:0] KD_RESET = 32'd0;

    // Lane stages plus the merged output register.
    localparam int LANE_STAGES = 4;
    localparam int PIPE_STAGES = LANE_STAGES + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP = 2'd0,
        CFG_KI = 2'd1,
        CFG_KD = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        ITEM_VEL = 1'b0,
        ITEM_TGT = 1'b1
    } t_item_kind;

    typedef struct packed {
        logic [PIPE_STAGES-1:0] en;
        logic                   vel_accept;
        logic                   tgt_accept;
    } t_pipe_ctl;

endpackage
`default_nettype wire

>>> rtl/core/qpid_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qpid_in_if: request channel into the controller
// Carries the item kind and one signed value per channel.
// ---------------------------------------------------------------------------
interface qpid_in_if
    import qpid_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic signed [VALUE_W-1:0] value_0;
    logic signed [VALUE_W-1:0] value_1;
    logic signed [VALUE_W-1:0] value_2;
    logic signed [VALUE_W-1:0] value_3;

    modport source (output valid, kind, value_0, value_1, value_2, value_3, input ready);
    modport sink   (input valid, kind, value_0, value_1, value_2, value_3, output ready);
endinterface
`default_nettype wire

>>> rtl/core/qpid_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qpid_out_if: torque result channel
// Carries one signed torque command per channel.
// ---------------------------------------------------------------------------
interface qpid_out_if
    import qpid_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [TORQUE_W-1:0] torque_0;
    logic signed [TORQUE_W-1:0] torque_1;
    logic signed [TORQUE_W-1:0] torque_2;
    logic signed [TORQUE_W-1:0] torque_3;

    modport source (output valid, torque_0, torque_1, torque_2, torque_3, input ready);
    modport sink   (input valid, torque_0, torque_1, torque_2, torque_3, output ready);
endinterface
`default_nettype wire

>>> rtl/core/qpid_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qpid_lane: PID datapath of one channel
// Holds the channel state and runs error, integral, products and sum in
// four register stages; the torque is formed from the last stage.
// ---------------------------------------------------------------------------
module qpid_lane
    import qpid_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_pipe_ctl                  i_ctl,
    input  wire logic signed [VALUE_W-1:0]  i_value,
    input  wire logic        [GAIN_W-1:0]   i_kp,
    input  wire logic        [GAIN_W-1:0]   i_ki,
    input  wire logic        [GAIN_W-1:0]   i_kd,
    output logic signed [TORQUE_W-1:0]      o_torque
);

    // Channel state
    logic signed [VALUE_W-1:0]        r_target;
    logic signed [ERR_W-1:0]          r_prev_err;
    logic signed [INTEGRAL_WIDTH-1:0] r_integ;

    // Stage 0
    logic signed [ERR_W-1:0]          r_e,   n_e;
    logic signed [DERR_W-1:0]         r_de,  n_de;
    logic signed [INTEGRAL_WIDTH-1:0] r_acc, n_acc;
    logic signed [INTEGRAL_WIDTH+1:0] n_sum;

    // Stage 1
    logic signed [KP_PROD_W-1:0]        r_kp_p;
    logic signed [KD_PROD_W-1:0]        r_kd_p;
    logic        [GAIN_W+INT_LO_W-1:0]  r_ki_lo;
    logic signed [GAIN_W+INT_HI_W:0]    r_ki_hi;

    // Stage 2
    logic signed [KI_EXT_W-1:0] n_ki_full;
    logic signed [U_W-1:0]      r_ki_c, n_ki_c;
    logic signed [PD_W-1:0]     r_pd;

    // Stage 3
    logic signed [U_W-1:0] r_u;

    logic        [U_W-1:0]      mag;
    logic        [U_W-1:0]      quot;
    logic        [TORQUE_W-2:0] clip;

    always_comb begin
        n_e  = {r_target[VALUE_W-1], r_target} - {i_value[VALUE_W-1], i_value};
        n_de = {n_e[ERR_W-1], n_e} - {r_prev_err[ERR_W-1], r_prev_err};
        n_sum = {{2{r_integ[INTEGRAL_WIDTH-1]}}, r_integ}
              + {{(INTEGRAL_WIDTH+2-ERR_W){r_prev_err[ERR_W-1]}}, r_prev_err}
              + {{(INTEGRAL_WIDTH+2-ERR_W){n_e[ERR_W-1]}}, n_e};
        // The integral saturates when the top three bits of the sum disagree.
        if ((n_sum[INTEGRAL_WIDTH+1:INTEGRAL_WIDTH-1] == 3'b000) ||
            (n_sum[INTEGRAL_WIDTH+1:INTEGRAL_WIDTH-1] == 3'b111)) begin
            n_acc = n_sum[INTEGRAL_WIDTH-1:0];
        end else if (n_sum[INTEGRAL_WIDTH+1]) begin
            n_acc = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};
        end else begin
            n_acc = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= '0;
            r_prev_err <= '0;
            r_integ    <= '0;
        end else begin
            if (i_ctl.tgt_accept) begin
                r_target <= i_value;
            end
            if (i_ctl.vel_accept) begin
                r_prev_err <= n_e;
                r_integ    <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_e   <= n_e;
            r_de  <= n_de;
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_kp_p  <= signed'({1'b0, i_kp}) * r_e;
            r_kd_p  <= signed'({1'b0, i_kd}) * r_de;
            r_ki_lo <= i_ki * r_acc[INT_LO_W-1:0];
            r_ki_hi <= signed'({1'b0, i_ki}) * signed'(r_acc[INTEGRAL_WIDTH-1:INT_LO_W]);
        end
    end

    // The integral term is held at plus or minus 2^61.
    always_comb begin
        n_ki_full = (KI_EXT_W'(r_ki_hi) <<< INT_LO_W) + signed'(KI_EXT_W'(r_ki_lo));
        if (n_ki_full > KI_EXT_W'(KI_TERM_LIMIT)) begin
            n_ki_c = KI_TERM_LIMIT;
        end else if (n_ki_full < -KI_EXT_W'(KI_TERM_LIMIT)) begin
            n_ki_c = -KI_TERM_LIMIT;
        end else begin
            n_ki_c = U_W'(n_ki_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_ki_c <= n_ki_c;
            r_pd   <= PD_W'(r_kp_p) + PD_W'(r_kd_p);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_u <= r_ki_c + U_W'(r_pd);
        end
    end

    // Truncate toward zero, clamp, then negate.
    always_comb begin
        mag  = r_u[U_W-1] ? U_W'(-r_u) : U_W'(r_u);
        quot = mag >> FRAC_BITS;
        clip = (quot > U_W'(TORQUE_LIMIT)) ? TORQUE_LIMIT : quot[TORQUE_W-2:0];
        o_torque = r_u[U_W-1] ? signed'({1'b0, clip}) : -signed'({1'b0, clip});
    end

endmodule
`default_nettype wire

>>> rtl/core/qpid_pipe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qpid_pipe_ctrl: valid tracking and stall control of the pipeline
// Each stage loads when it is empty or its successor loads, so bubbles
// collapse and the input keeps flowing while the output register waits.
// ---------------------------------------------------------------------------
module qpid_pipe_ctrl
    import qpid_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_kind,
    input  wire logic i_out_ready,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_pipe_ctl o_ctl
);

    logic [PIPE_STAGES-1:0] r_vld, n_vld;
    logic [PIPE_STAGES:0]   en;
    logic                   vel_accept;
    logic                   tgt_accept;

    always_comb begin
        en[PIPE_STAGES] = i_out_ready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign vel_accept = i_in_valid && en[0] && (i_in_kind == ITEM_VEL);
    assign tgt_accept = i_in_valid && en[0] && (i_in_kind == ITEM_TGT);

    always_comb begin
        n_vld = r_vld;
        if (en[0]) begin
            n_vld[0] = vel_accept;
        end
        for (int k = 1; k < PIPE_STAGES; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready       = en[0];
    assign o_out_valid      = r_vld[PIPE_STAGES-1];
    assign o_ctl.en         = en[PIPE_STAGES-1:0];
    assign o_ctl.vel_accept = vel_accept;
    assign o_ctl.tgt_accept = tgt_accept;

`ifndef ASSERT_OFF
    // The input only stalls when every stage holds a request.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en[0] |-> (&r_vld))
        else $error("input stalled with an empty pipeline stage");

    // A target update never produces a result.
    a_tgt_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tgt_accept |=> !r_vld[0])
        else $error("target update entered the pipeline");

    // A finished sum moves into an open output register.
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[PIPE_STAGES-2] && en[PIPE_STAGES-1]) |=> r_vld[PIPE_STAGES-1])
        else $error("result lost on the way to the output register");

    // A waiting result is never overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[PIPE_STAGES-1] && !i_out_ready) |-> !en[PIPE_STAGES-1])
        else $error("output register reloaded while stalled");
`endif

endmodule
`default_nettype wire

>>> rtl/core/quad_pid_velocity_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// quad_pid_velocity_controller: four-channel PID speed controller
// Usage:
//   i_in carries requests. kind 1 loads the four targets and gives no result;
//   kind 0 carries four encoder velocities and gives one result on o_out
//   with the four torque commands.
//   Gains are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle
//   (0 kp, 1 ki, 2 kd; index 3 is ignored).
//   A result passes the error/integral, products, partial sums and total
//   stages and is then registered in the output register.
//   Throughput: one request per cycle while the pipeline is not stalled; the
//   four channels run in parallel lanes and the output register merges them.
//   Reset (synchronous, active low) clears targets, previous errors and
//   integrals and loads the default gains.
//   When the receiver stalls, the result waits in the output register and
//   the five-deep pipeline keeps accepting until every stage is full.
// ---------------------------------------------------------------------------
module quad_pid_velocity_controller
    import qpid_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    qpid_in_if.sink                    i_in,
    qpid_out_if.source                 o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [GAIN_W-1:0]     i_cfg_data
);

    logic [GAIN_W-1:0] r_kp;
    logic [GAIN_W-1:0] r_ki;
    logic [GAIN_W-1:0] r_kd;

    t_pipe_ctl ctl;
    logic      in_ready;
    logic      out_valid;

    logic signed [VALUE_W-1:0]  in_vals     [IO_LANES];
    logic signed [VALUE_W-1:0]  lane_val    [CHANNELS];
    logic signed [TORQUE_W-1:0] lane_torque [CHANNELS];
    logic signed [TORQUE_W-1:0] r_torque    [IO_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= KP_RESET;
            r_ki <= KI_RESET;
            r_kd <= KD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KP: begin
                    r_kp <= i_cfg_data;
                end
                CFG_KI: begin
                    r_ki <= i_cfg_data;
                end
                CFG_KD: begin
                    r_kd <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    qpid_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_kind   (i_in.kind),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_ctl       (ctl)
    );

    assign i_in.ready = in_ready;

    assign in_vals[0] = i_in.value_0;
    assign in_vals[1] = i_in.value_1;
    assign in_vals[2] = i_in.value_2;
    assign in_vals[3] = i_in.value_3;

    for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
        // Channels beyond the value fields see a velocity and target of zero.
        if (ch < IO_LANES) begin : g_io
            assign lane_val[ch] = in_vals[ch];
        end else begin : g_zero
            assign lane_val[ch] = '0;
        end

        qpid_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_value  (lane_val[ch]),
            .i_kp     (r_kp),
            .i_ki     (r_ki),
            .i_kd     (r_kd),
            .o_torque (lane_torque[ch])
        );
    end

    for (genvar i = 0; i < IO_LANES; i++) begin : g_out
        if (i < CHANNELS) begin : g_used
            always_ff @(posedge i_clk) begin
                if (ctl.en[PIPE_STAGES-1]) begin
                    r_torque[i] <= lane_torque[i];
                end
            end
        end else begin : g_unused
            assign r_torque[i] = '0;
        end
    end

    assign o_out.valid    = out_valid;
    assign o_out.torque_0 = r_torque[0];
    assign o_out.torque_1 = r_torque[1];
    assign o_out.torque_2 = r_torque[2];
    assign o_out.torque_3 = r_torque[3];

endmodule
`default_nettype wire
